[sv/skf_pkg.sv]
`timescale 1ns / 1ps

package skf_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CHAR_W       = 7;
  localparam int CODE_W       = 8;
  localparam int TABLE_LEN    = 58;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

  typedef enum logic [1:0] {
    REQ_SCANCODE = 2'd0,
    REQ_READ     = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_NONE     = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_OUT
  } skf_state_t;

  // controller -> datapath
  typedef struct packed {
    logic push;       // write translated char, bump write pointer
    logic pop;        // read buffer head, bump read pointer
    logic clear;      // both pointers back to zero
    logic ld_status;  // load result flags, zero the char
    logic ld_char;    // load popped char from ram
  } skf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic char_ok;
  } skf_status_t;

  // scancode set 1, us layout; zero marks an unmapped code
  localparam logic [CHAR_W-1:0] KEY_TABLE [TABLE_LEN] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  function automatic logic [CHAR_W-1:0] key_lookup(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    ch = '0;
    if (code[7:6] == 2'b00 && code[5:0] < 6'(TABLE_LEN)) begin
      ch = KEY_TABLE[code[5:0]];
    end
    return ch;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

endpackage

[sv/skf_ram.sv]
`timescale 1ns / 1ps

module skf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/skf_ctrl.sv]
`timescale 1ns / 1ps

module skf_ctrl
  import skf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  output logic        out_valid,
  input  logic        out_ready,
  input  skf_status_t status,
  output skf_cmd_t    cmd
);

  skf_state_t state_r;
  skf_state_t state_nxt;
  logic       accept;
  req_type_t  req;

  assign req    = req_type_t'(req_type);
  assign accept = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (req == REQ_READ && !status.empty) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_FETCH: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.ld_status = 1'b1;
          case (req)
            REQ_SCANCODE: cmd.push  = status.char_ok && !status.full;
            REQ_READ:     cmd.pop   = !status.empty;
            REQ_CLEAR:    cmd.clear = 1'b1;
            default:      cmd.push  = 1'b0;
          endcase
        end
      end
      ST_FETCH: cmd.ld_char = 1'b1;
      ST_OUT:   out_valid   = 1'b1;
      default:  out_valid   = 1'b0;
    endcase
  end

endmodule

[sv/skf_dp.sv]
`timescale 1ns / 1ps

module skf_dp
  import skf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  skf_cmd_t          cmd,
  input  logic [CODE_W-1:0] scancode,
  output skf_status_t       status,
  output logic [CHAR_W-1:0] key_char,
  output logic              key_valid,
  output logic              has_key
);

  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CHAR_W-1:0] key_char_r, key_char_nxt;
  logic              key_valid_r, key_valid_nxt;
  logic              has_key_r, has_key_nxt;
  logic [CHAR_W-1:0] xlat_char;
  logic [CHAR_W-1:0] ram_rdata;

  assign xlat_char = key_lookup(scancode);

  assign status.empty   = (wr_ptr_r == rd_ptr_r);
  assign status.full    = (ptr_advance(wr_ptr_r) == rd_ptr_r);
  assign status.char_ok = (xlat_char != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.clear) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
    end else begin
      if (cmd.push) wr_ptr_nxt = ptr_advance(wr_ptr_r);
      if (cmd.pop)  rd_ptr_nxt = ptr_advance(rd_ptr_r);
    end
  end

  always_comb begin
    key_char_nxt  = key_char_r;
    key_valid_nxt = key_valid_r;
    has_key_nxt   = has_key_r;
    if (cmd.ld_status) begin
      key_char_nxt  = '0;
      key_valid_nxt = cmd.pop;
      has_key_nxt   = (wr_ptr_nxt != rd_ptr_nxt);
    end else if (cmd.ld_char) begin
      key_char_nxt  = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_char_r  <= key_char_nxt;
    key_valid_r <= key_valid_nxt;
    has_key_r   <= has_key_nxt;
  end

  skf_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_ptr_r),
    .wdata (xlat_char),
    .re    (cmd.pop),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign key_char  = key_char_r;
  assign key_valid = key_valid_r;
  assign has_key   = has_key_r;

endmodule

[sv/scancode_to_ascii_key_fifo.sv]
`timescale 1ns / 1ps

// keyboard key buffer: set 1 scancodes in, ascii characters out
// input channel (in_valid/in_ready): one request per beat, in_req_type
//   selects scancode push, key read or buffer clear; in_scancode is used
//   only for a push; release codes and unmapped codes are dropped
// output channel (out_valid/out_ready): exactly one result beat per request,
//   carrying the popped char (or zero), whether a char was popped and
//   whether the buffer still holds a key
// buffer holds BUFFER_DEPTH - 1 chars; a push into a full buffer is lost
// result valid in the cycle after accept; a read that pops first passes through
//   the fetch state for the registered ram read
// throughput: one request in flight; no new request is taken until the result
//   is taken, so the receiver holding out_ready low holds off the next request
// stall: the result sits in the output registers until taken, in_ready stays
//   low meanwhile
// reset (rst_n low, synchronous): both pointers go to zero, buffer is empty;
//   the character ram is not cleared, only written slots are ever read
module scancode_to_ascii_key_fifo
  import skf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [CODE_W-1:0] in_scancode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_key_char,
  output logic              out_key_valid,
  output logic              out_has_key
);

  // control and status between sequencer and datapath
  skf_cmd_t    cmd;
  skf_status_t status;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (in_req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // pointers, translation table, char ram and result registers
  skf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .scancode  (in_scancode),
    .status    (status),
    .key_char  (out_key_char),
    .key_valid (out_key_valid),
    .has_key   (out_has_key)
  );

endmodule
